// ===== rtl/core/lcg_pkg.sv =====
package lcg_pkg;

	// Fixed field widths of the channels
	localparam int unsigned OP_W       = 2;
	localparam int unsigned TIDX_W     = 8;
	localparam int unsigned TVAL_W     = 16;
	localparam int unsigned EVAL_W     = 16;
	localparam int unsigned EPOS_W     = 4;
	localparam int unsigned CNT_W      = 9;
	localparam int unsigned CHS_W      = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// Request codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_RESTART = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 2'd1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_ADV_RD,
		ST_ADV_CMP,
		ST_REFILL,
		ST_EM_SEL,
		ST_EM_VAL,
		ST_EM_OUT,
		ST_EXH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic tbl_wr;      // write item table from the request
		logic pos_clr;     // position counter to zero
		logic pos_top;     // position counter to k-1
		logic pos_inc;
		logic pos_dec;
		logic sel_fill;    // index[pos] = pos
		logic sel_grow;    // index[pos] = read index + 1, load run value
		logic sel_run;     // index[pos] = run value + 1, advance run value
		logic sel_rd;      // read index at pos
		logic sel_rd_next; // read index at pos+1
		logic item_rd;     // read item table at the read index
		logic out_elem;    // load an element result
		logic out_exh;     // load the exhausted result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic bad_nk;   // k is zero or n < k
		logic grow;     // read index is below its limit
		logic pos_zero;
		logic pos_last; // pos is k-1
		logic out_free; // output register can take a result
	} stat_t;

endpackage

// ===== rtl/core/lcg_if.sv =====
interface lcg_item_if;
	logic                        valid;
	logic                        ready;
	logic [lcg_pkg::OP_W-1:0]    op;
	logic [lcg_pkg::TIDX_W-1:0]  table_index;
	logic [lcg_pkg::TVAL_W-1:0]  table_value;

	modport source (output valid, op, table_index, table_value, input ready);
	modport sink (input valid, op, table_index, table_value, output ready);
endinterface

interface lcg_result_if;
	logic                        valid;
	logic                        ready;
	logic [lcg_pkg::EVAL_W-1:0]  element_value;
	logic [lcg_pkg::EPOS_W-1:0]  element_position;
	logic                        last_element;
	logic                        exhausted;

	modport source (output valid, element_value, element_position, last_element, exhausted,
		input ready);
	modport sink (input valid, element_value, element_position, last_element, exhausted,
		output ready);
endinterface

interface lcg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lcg_pkg::CFG_IDX_W-1:0]   index;
	logic [lcg_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lcg_ctrl.sv =====
module lcg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [lcg_pkg::OP_W-1:0]  in_op,
	input  lcg_pkg::stat_t            stat,
	output logic                      in_ready,
	output lcg_pkg::cmd_t             cmd
);

	lcg_pkg::state_t state_q, state_d;
	logic started_q, started_d;
	logic done_q, done_d;

	// State and sequence flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lcg_pkg::ST_IDLE;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			done_q    <= done_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		done_d    = done_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			lcg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == lcg_pkg::OP_WRITE) begin
						cmd.tbl_wr = 1'b1;
					end else if (in_op == lcg_pkg::OP_RESTART ||
							(in_op == lcg_pkg::OP_ADVANCE && !started_q)) begin
						started_d = 1'b1;
						done_d    = 1'b0;
						if (stat.bad_nk) begin
							done_d  = 1'b1;
							state_d = lcg_pkg::ST_EXH;
						end else begin
							cmd.pos_clr = 1'b1;
							state_d     = lcg_pkg::ST_FILL;
						end
					end else if (in_op == lcg_pkg::OP_ADVANCE) begin
						if (done_q || stat.bad_nk) begin
							done_d  = 1'b1;
							state_d = lcg_pkg::ST_EXH;
						end else begin
							cmd.pos_top = 1'b1;
							state_d     = lcg_pkg::ST_ADV_RD;
						end
					end
				end
			end
			// Load the first selection, one index a cycle
			lcg_pkg::ST_FILL: begin
				cmd.sel_fill = 1'b1;
				if (stat.pos_last) begin
					cmd.pos_clr = 1'b1;
					state_d     = lcg_pkg::ST_EM_SEL;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			// Scan from the right for an index that can grow
			lcg_pkg::ST_ADV_RD: begin
				cmd.sel_rd = 1'b1;
				state_d    = lcg_pkg::ST_ADV_CMP;
			end
			lcg_pkg::ST_ADV_CMP: begin
				if (stat.grow) begin
					cmd.sel_grow = 1'b1;
					if (stat.pos_last) begin
						cmd.pos_clr = 1'b1;
						state_d     = lcg_pkg::ST_EM_SEL;
					end else begin
						cmd.pos_inc = 1'b1;
						state_d     = lcg_pkg::ST_REFILL;
					end
				end else if (stat.pos_zero) begin
					done_d  = 1'b1;
					state_d = lcg_pkg::ST_EXH;
				end else begin
					cmd.pos_dec = 1'b1;
					state_d     = lcg_pkg::ST_ADV_RD;
				end
			end
			// Refill later indices with consecutive values
			lcg_pkg::ST_REFILL: begin
				cmd.sel_run = 1'b1;
				if (stat.pos_last) begin
					cmd.pos_clr = 1'b1;
					state_d     = lcg_pkg::ST_EM_SEL;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			// Emit elements: index read, value read, output load
			lcg_pkg::ST_EM_SEL: begin
				cmd.sel_rd = 1'b1;
				state_d    = lcg_pkg::ST_EM_VAL;
			end
			lcg_pkg::ST_EM_VAL: begin
				cmd.item_rd = 1'b1;
				state_d     = lcg_pkg::ST_EM_OUT;
			end
			lcg_pkg::ST_EM_OUT: begin
				if (stat.out_free) begin
					cmd.out_elem = 1'b1;
					if (stat.pos_last) begin
						state_d = lcg_pkg::ST_IDLE;
					end else begin
						cmd.pos_inc     = 1'b1;
						cmd.sel_rd_next = 1'b1;
						state_d         = lcg_pkg::ST_EM_VAL;
					end
				end
			end
			lcg_pkg::ST_EXH: begin
				if (stat.out_free) begin
					cmd.out_exh = 1'b1;
					state_d     = lcg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcg_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_done_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> started_q)
		else $error("sequence done without a start");

	a_exh_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcg_pkg::ST_EXH && stat.out_free) |=> state_q == lcg_pkg::ST_IDLE)
		else $error("exhausted result not completed");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcg_pkg::ST_ADV_CMP && !stat.grow && stat.pos_zero)
		|=> (state_q == lcg_pkg::ST_EXH && done_q))
		else $error("failed scan did not finish the sequence");

	a_restart_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == lcg_pkg::OP_RESTART)
		|=> (started_q && (state_q == lcg_pkg::ST_FILL || state_q == lcg_pkg::ST_EXH)))
		else $error("restart did not start a sequence");
`endif

endmodule

// ===== rtl/core/lcg_datapath.sv =====
module lcg_datapath #(
	parameter int MAX_ITEMS  = 256,
	parameter int MAX_CHOOSE = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [lcg_pkg::TIDX_W-1:0]      tbl_index,
	input  logic [lcg_pkg::TVAL_W-1:0]      tbl_value,
	input  lcg_pkg::cmd_t                   cmd,
	input  logic                            out_ready,
	output lcg_pkg::stat_t                  stat,
	output logic                            out_valid,
	output logic [lcg_pkg::EVAL_W-1:0]      element_value,
	output logic [lcg_pkg::EPOS_W-1:0]      element_position,
	output logic                            last_element,
	output logic                            exhausted
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int NW = $clog2(MAX_ITEMS + 1);
	localparam int KW = $clog2(MAX_CHOOSE + 1);
	localparam int PW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
	localparam int AW = ((NW > KW) ? NW : KW) + 1;

	logic [lcg_pkg::CNT_W-1:0] item_count_q;
	logic [lcg_pkg::CHS_W-1:0] choose_count_q;
	logic [NW-1:0]             n_eff;
	logic [KW-1:0]             k_eff;
	logic [KW-1:0]             pos_q;
	logic [KW-1:0]             pos_nx;
	logic [IW-1:0]             sel_rd_q;
	logic [IW-1:0]             run_q;
	logic [VALUE_BITS-1:0]     item_rd_q;
	logic [AW-1:0]             limit;
	logic [IW-1:0]             sel_wdata;
	logic [PW-1:0]             sel_raddr;
	logic                      tbl_in_range;

	logic [IW-1:0]         sel_mem [MAX_CHOOSE];
	logic [VALUE_BITS-1:0] item_mem [MAX_ITEMS];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q   <= '0;
			choose_count_q <= lcg_pkg::CHS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcg_pkg::CFG_ITEM_COUNT:   item_count_q   <= cfg_data[lcg_pkg::CNT_W-1:0];
				lcg_pkg::CFG_CHOOSE_COUNT: choose_count_q <= cfg_data[lcg_pkg::CHS_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate n and k to the storage limits
	assign n_eff = (32'(item_count_q) > 32'(MAX_ITEMS)) ? NW'(MAX_ITEMS) : NW'(item_count_q);
	assign k_eff = (32'(choose_count_q) > 32'(MAX_CHOOSE)) ? KW'(MAX_CHOOSE)
		: KW'(choose_count_q);

	assign pos_nx = pos_q + KW'(1);
	assign limit  = AW'(n_eff) - AW'(k_eff) + AW'(pos_q);

	assign stat.bad_nk   = (k_eff == '0) || (AW'(n_eff) < AW'(k_eff));
	assign stat.grow     = AW'(sel_rd_q) < limit;
	assign stat.pos_zero = (pos_q == '0);
	assign stat.pos_last = (AW'(pos_q) + AW'(1)) == AW'(k_eff);
	assign stat.out_free = !out_valid || out_ready;

	// Position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.pos_clr) begin
			pos_q <= '0;
		end else if (cmd.pos_top) begin
			pos_q <= k_eff - KW'(1);
		end else if (cmd.pos_inc) begin
			pos_q <= pos_nx;
		end else if (cmd.pos_dec) begin
			pos_q <= pos_q - KW'(1);
		end
	end

	// Index memory write data and read address
	always_comb begin
		if (cmd.sel_fill) begin
			sel_wdata = IW'(pos_q);
		end else if (cmd.sel_grow) begin
			sel_wdata = sel_rd_q + IW'(1);
		end else begin
			sel_wdata = run_q + IW'(1);
		end
	end

	assign sel_raddr = cmd.sel_rd_next ? pos_nx[PW-1:0] : pos_q[PW-1:0];

	// Index memory, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHOOSE; i++) begin
				sel_mem[i] <= '0;
			end
		end else if (cmd.sel_fill || cmd.sel_grow || cmd.sel_run) begin
			sel_mem[pos_q[PW-1:0]] <= sel_wdata;
		end
	end

	// Index read and run value
	always_ff @(posedge clk) begin
		if (cmd.sel_rd || cmd.sel_rd_next) begin
			sel_rd_q <= sel_mem[sel_raddr];
		end
		if (cmd.sel_grow || cmd.sel_run) begin
			run_q <= sel_wdata;
		end
	end

	// Item table
	assign tbl_in_range = 32'(tbl_index) < 32'(MAX_ITEMS);

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && tbl_in_range) begin
			item_mem[IW'(tbl_index)] <= VALUE_BITS'(tbl_value);
		end
		if (cmd.item_rd) begin
			item_rd_q <= item_mem[sel_rd_q];
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_elem || cmd.out_exh) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_elem) begin
			element_value    <= lcg_pkg::EVAL_W'(item_rd_q);
			element_position <= lcg_pkg::EPOS_W'(pos_q);
			last_element     <= stat.pos_last;
			exhausted        <= 1'b0;
		end else if (cmd.out_exh) begin
			element_value    <= '0;
			element_position <= '0;
			last_element     <= 1'b1;
			exhausted        <= 1'b1;
		end
	end

endmodule

// ===== rtl/core/lexicographic_combination_generator_unit.sv =====
// Sequence: a table write completes in the idle state; a restart loads the selection, then
// emits each element by an index read, a value read and an output load; an advance scans
// indices from the right, refills those after the one that grows, then emits likewise; an
// exhausted answer is loaded from its own state. One request at a time: the input is ready
// only while idle, and each output load waits while an unaccepted result is held.
// Reset clears sequencer, flags, selection indices, output valid; n=0, k=1; table undefined.
module lexicographic_combination_generator_unit #(
	parameter int MAX_ITEMS  = 256,
	parameter int MAX_CHOOSE = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	lcg_item_if.sink      item,
	lcg_result_if.source  result,
	lcg_cfg_if.sink       cfg
);

	lcg_pkg::cmd_t  cmd;
	lcg_pkg::stat_t stat;
	logic           in_ready;

	// Configuration always accepted
	assign cfg.ready  = 1'b1;
	assign item.ready = in_ready;

	lcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	lcg_datapath #(
		.MAX_ITEMS  (MAX_ITEMS),
		.MAX_CHOOSE (MAX_CHOOSE),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.tbl_index        (item.table_index),
		.tbl_value        (item.table_value),
		.cmd              (cmd),
		.out_ready        (result.ready),
		.stat             (stat),
		.out_valid        (result.valid),
		.element_value    (result.element_value),
		.element_position (result.element_position),
		.last_element     (result.last_element),
		.exhausted        (result.exhausted)
	);

endmodule

// ===== sim/lcg_combination_check.sv =====
module lcg_combination_check (
	input  logic  clk,
	input  logic  arst_n,
	lcg_item_if   item,
	lcg_result_if result,
	lcg_cfg_if    cfg,
	output int    pending,
	output int    mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 256;
	localparam int PICK_DEPTH  = 16;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [lcg_pkg::EVAL_W-1:0] value;
		logic [lcg_pkg::EPOS_W-1:0] position;
		logic                       last;
		logic                       exhausted;
	} element_t;

	// Shadow of the generator: setting, selected positions, item table, walk flags
	logic [lcg_pkg::CNT_W-1:0]  n_items;
	logic [lcg_pkg::CHS_W-1:0]  k_choose;
	logic [lcg_pkg::TIDX_W-1:0] picks [PICK_DEPTH];
	logic [lcg_pkg::EVAL_W-1:0] values [TABLE_DEPTH];
	logic                       walk_open;
	logic                       walk_over;
	element_t                   due_q [$];
	int                         fail_count = 0;

	// Add one expected element at the tail of the queue
	task automatic append_due(input element_t e);
		due_q.insert(due_q.size(), e);
	endtask

	// Queue the single answer that says no combination is left, and close the walk
	task automatic push_exhausted();
		element_t e;
		walk_over   = 1'b1;
		e.value     = '0;
		e.position  = '0;
		e.last      = 1'b1;
		e.exhausted = 1'b1;
		append_due(e);
	endtask

	// Queue one element per selected position, the final one marked
	task automatic push_selection(input int k);
		element_t e;
		for (int p = 0; p < k; p++) begin
			e.value     = values[picks[p]];
			e.position  = lcg_pkg::EPOS_W'(p);
			e.last      = (p == k - 1);
			e.exhausted = 1'b0;
			append_due(e);
		end
	endtask

	// Work out the elements that one request produces and update the shadow state
	task automatic predict_request(input lcg_pkg::op_t op,
		input logic [lcg_pkg::TIDX_W-1:0] idx, input logic [lcg_pkg::TVAL_W-1:0] val);
		int n;
		int k;
		int i;
		n = (n_items > TABLE_DEPTH) ? TABLE_DEPTH : int'(n_items);
		k = (k_choose > PICK_DEPTH) ? PICK_DEPTH : int'(k_choose);
		case (op)
			lcg_pkg::OP_WRITE: begin
				values[idx] = val;
			end
			lcg_pkg::OP_NONE: begin
			end
			default: begin
				if (op == lcg_pkg::OP_RESTART || !walk_open) begin
					// Restart, also taken by an advance that finds no walk begun
					walk_open = 1'b1;
					walk_over = 1'b0;
					if (k == 0 || n < k) begin
						push_exhausted();
					end else begin
						for (int p = 0; p < k; p++)
							picks[p] = lcg_pkg::TIDX_W'(p);
						push_selection(k);
					end
				end else if (walk_over || k == 0 || n < k) begin
					push_exhausted();
				end else begin
					// Find the rightmost position still below its limit
					i = k - 1;
					while (i >= 0 && int'(picks[i]) >= n - k + i)
						i--;
					if (i < 0) begin
						push_exhausted();
					end else begin
						picks[i] = picks[i] + 1'b1;
						for (int p = i + 1; p < k; p++)
							picks[p] = picks[p-1] + 1'b1;
						push_selection(k);
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		element_t got;
		element_t want;
		if (!arst_n) begin
			n_items   = '0;
			k_choose  = lcg_pkg::CHS_W'(1);
			walk_open = 1'b0;
			walk_over = 1'b0;
			for (int p = 0; p < PICK_DEPTH; p++)
				picks[p] = '0;
			due_q.delete();
		end else begin
			// Apply register writes
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == lcg_pkg::CFG_ITEM_COUNT)
					n_items = cfg.data[lcg_pkg::CNT_W-1:0];
				else if (cfg.index == lcg_pkg::CFG_CHOOSE_COUNT)
					k_choose = cfg.data[lcg_pkg::CHS_W-1:0];
			end

			// Predict on every request transfer
			if (item.valid && item.ready)
				predict_request(lcg_pkg::op_t'(item.op), item.table_index, item.table_value);

			// Compare every result transfer with the oldest prediction
			if (result.valid && result.ready) begin
				got.value     = result.element_value;
				got.position  = result.element_position;
				got.last      = result.last_element;
				got.exhausted = result.exhausted;
				if (due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("%0t: result with nothing predicted:", $time,
							" value=%h pos=%0d last=%b exh=%b",
							got.value, got.position, got.last, got.exhausted);
				end else begin
					want = due_q.pop_front();
					if (got.value !== want.value || got.position !== want.position ||
						got.last !== want.last || got.exhausted !== want.exhausted) begin
						fail_count++;
						if (fail_count <= SHOW_LIMIT)
							$display("%0t: mismatch: expected value=%h pos=%0d last=%b exh=%b,",
								$time, want.value, want.position, want.last, want.exhausted,
								" got value=%h pos=%0d last=%b exh=%b",
								got.value, got.position, got.last, got.exhausted);
					end
				end
			end
		end
		pending    <= due_q.size();
		mismatches <= fail_count;
	end

endmodule

// ===== sim/tb_lexicographic_combination_generator_unit.sv =====
module tb_lexicographic_combination_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int RANDOM_REQUESTS = 145;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam int TABLE_FILL      = 64;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic steady    = 1'b0;
	logic hold_kick = 1'b0;
	logic sink_hold = 1'b0;
	int   pending;
	int   mismatches;
	int   cycle_count = 0;

	lcg_item_if   item_ch ();
	lcg_result_if result_ch ();
	lcg_cfg_if    cfg_ch ();

	lexicographic_combination_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	lcg_combination_check combo_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always #5ns clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side: random stalls, forced low while the long hold-off runs
	initial begin : sink_side
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left   = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left   = $urandom_range(0, 12);
					stall_left = idle_length();
				end
			end
		end
	end

	// Hold off the result side for a long stretch once asked
	initial begin : sink_hold_off
		wait (hold_kick);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Offer one request and wait for its transfer
	task automatic offer(input lcg_pkg::op_t op, input logic [lcg_pkg::TIDX_W-1:0] idx,
		input logic [lcg_pkg::TVAL_W-1:0] val);
		item_ch.valid       <= 1'b1;
		item_ch.op          <= op;
		item_ch.table_index <= idx;
		item_ch.table_value <= val;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// Insert a random gap, then offer the request
	task automatic issue(input lcg_pkg::op_t op, input logic [lcg_pkg::TIDX_W-1:0] idx,
		input logic [lcg_pkg::TVAL_W-1:0] val);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		offer(op, idx, val);
	endtask

	// Stop offering until every predicted result is in and the block is quiet
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write item count then choose count, valid held across both transfers
	task automatic configure(input int n, input int k);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= lcg_pkg::CFG_ITEM_COUNT;
		cfg_ch.data  <= lcg_pkg::CFG_DATA_W'(n);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= lcg_pkg::CFG_CHOOSE_COUNT;
		cfg_ch.data  <= lcg_pkg::CFG_DATA_W'(k);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int           issued;
		int           phase_len;
		int           r;
		lcg_pkg::op_t op;
		item_ch.valid       <= 1'b0;
		item_ch.op          <= lcg_pkg::OP_NONE;
		item_ch.table_index <= '0;
		item_ch.table_value <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= lcg_pkg::CFG_ITEM_COUNT;
		cfg_ch.data         <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the low part of the table that every walk reads, extreme values at both ends
		configure(4, 2);
		for (int i = 0; i < TABLE_FILL; i++) begin
			if (i == 0 || i == TABLE_FILL - 1)
				issue(lcg_pkg::OP_WRITE, lcg_pkg::TIDX_W'(i), '1);
			else if (i == 1)
				issue(lcg_pkg::OP_WRITE, lcg_pkg::TIDX_W'(i), '0);
			else
				issue(lcg_pkg::OP_WRITE, lcg_pkg::TIDX_W'(i), lcg_pkg::TVAL_W'($urandom));
		end

		// Advance with no walk begun acts as restart; unused code is dropped
		issue(lcg_pkg::OP_ADVANCE, '0, '0);
		issue(lcg_pkg::OP_NONE, '1, '1);
		// Walk to the last pair, then run past the end twice
		repeat (5) issue(lcg_pkg::OP_ADVANCE, '0, '0);
		repeat (2) issue(lcg_pkg::OP_ADVANCE, '1, '1);
		issue(lcg_pkg::OP_RESTART, '0, '0);

		// Single combination when n equals k
		settle();
		configure(3, 3);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);

		// Too few items
		settle();
		configure(2, 5);
		issue(lcg_pkg::OP_RESTART, '0, '0);

		// Zero choose count
		settle();
		configure(5, 0);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);

		// Both counts above their maxima saturate
		settle();
		configure(511, 31);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);

		// Change the setting in the middle of a walk
		settle();
		configure(256, 16);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);
		settle();
		configure(5, 3);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);

		// Reset setting, then the first steps of a single-element walk over the full table
		settle();
		configure(0, 1);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		settle();
		configure(256, 1);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		issue(lcg_pkg::OP_ADVANCE, '0, '0);

		// Hold off results while requests keep coming, so the input stalls
		settle();
		configure(256, 16);
		issue(lcg_pkg::OP_RESTART, '0, '0);
		hold_kick <= 1'b1;
		repeat (12) offer(lcg_pkg::OP_ADVANCE, lcg_pkg::TIDX_W'($urandom),
			lcg_pkg::TVAL_W'($urandom));

		// Random phases: mostly advances through walks of random setting
		issued = 0;
		while (issued < RANDOM_REQUESTS) begin
			settle();
			steady <= ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 6)
				configure($urandom_range(0, 9), $urandom_range(1, 5));
			else if (r == 6)
				configure($urandom_range(40, TABLE_FILL), $urandom_range(8, 31));
			else if (r == 7)
				configure($urandom_range(0, 12), $urandom_range(0, 31));
			// otherwise keep the setting and resume the walk
			if ($urandom_range(0, 9) < 7) begin
				issue(lcg_pkg::OP_RESTART, lcg_pkg::TIDX_W'($urandom),
					lcg_pkg::TVAL_W'($urandom));
				issued++;
			end
			phase_len = $urandom_range(4, 24);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 82)
					op = lcg_pkg::OP_ADVANCE;
				else if (r < 88)
					op = lcg_pkg::OP_RESTART;
				else if (r < 96)
					op = lcg_pkg::OP_WRITE;
				else
					op = lcg_pkg::OP_NONE;
				issue(op, lcg_pkg::TIDX_W'($urandom), lcg_pkg::TVAL_W'($urandom));
				if (op != lcg_pkg::OP_NONE)
					issued++;
			end
		end

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
